// ===== rtl/three_wire_rtc_access_master_defines.svh =====
// Assertion macros for the three-wire RTC access master.
// Included by the top level; no other dependencies.
`ifndef THREE_WIRE_RTC_ACCESS_MASTER_DEFINES_SVH
`define THREE_WIRE_RTC_ACCESS_MASTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define RTCAM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define RTCAM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define RTCAM_ASSERT(lbl, clk, rstn, prop, msg)
`define RTCAM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/rtcam_pkg.sv =====
// Shared types, codes and BCD helpers for the three-wire RTC access master.
// No dependencies.
package rtcam_pkg;

    localparam logic [1:0] OP_WRITE_RAW = 2'd0;
    localparam logic [1:0] OP_WRITE_DEC = 2'd1;
    localparam logic [1:0] OP_READ_RAW  = 2'd2;
    localparam logic [1:0] OP_READ_DEC  = 2'd3;

    localparam logic [7:0] CMD_BASE  = 8'h80;
    localparam logic [7:0] CMD_READ  = 8'h01;
    localparam logic [5:0] LAST_TICK = 6'd32;
    localparam int         ITEM_W    = 15;

    // lowest bit first: start_req, opcode, reg_index, value, io_in
    typedef struct packed {
        logic       io_in;
        logic [7:0] value;
        logic [2:0] reg_index;
        logic [1:0] opcode;
        logic       start_req;
    } t_item;

    // lowest bit first: sclk, io_out, io_drive, chip_enable, busy, done, read_value
    typedef struct packed {
        logic [7:0] read_value;
        logic       done_res;
        logic       busy_res;
        logic       chip_enable;
        logic       io_drive;
        logic       io_out;
        logic       sclk;
    } t_result;

    // decimal to BCD, clamped at 99; divide by 10 via 205/2048
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [6:0]  c;
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  q10;
        logic [6:0]  r;
        c    = (v > 8'd99) ? 7'd99 : v[6:0];
        prod = 15'(c) * 15'd205;
        q    = prod[14:11];
        q10  = {q, 3'b000} + 7'({q, 1'b0});
        r    = c - q10;
        return {q, r[3:0]};
    endfunction

    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0000, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
    endfunction

endpackage

// ===== rtl/rtcam_core.sv =====
// Access sequencer: per-tick state update and pin/result computation.
// Depends on rtcam_pkg.
module rtcam_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  rtcam_pkg::t_item i_item,
    output rtcam_pkg::t_result o_res
);
    import rtcam_pkg::*;

    logic [5:0] r_phase, n_phase;
    logic [1:0] r_mode,  n_mode;
    logic [7:0] r_cmd,   n_cmd;
    logic [7:0] r_data,  n_data;
    logic [7:0] r_cap,   n_cap;

    logic       idle;
    logic [1:0] mode;
    logic [7:0] cmd, dat, cap;
    logic       second, odd;

    assign idle = (r_phase == 6'd0);

    always_comb begin
        t_result res;
        res       = '0;
        res.io_drive = 1'b1;
        n_phase   = r_phase;
        n_mode    = r_mode;
        n_cmd     = r_cmd;
        n_data    = r_data;
        n_cap     = r_cap;
        mode      = r_mode;
        cmd       = r_cmd;
        dat       = r_data;
        cap       = r_cap;
        second    = r_phase[4];
        odd       = r_phase[0];

        // a start in idle latches the access and runs tick 0 at once
        if (idle) begin
            mode = i_item.opcode;
            cmd  = CMD_BASE + {4'b0000, i_item.reg_index, 1'b0}
                   + (i_item.opcode[1] ? CMD_READ : 8'h00);
            case (i_item.opcode)
                OP_WRITE_RAW: dat = i_item.value;
                OP_WRITE_DEC: dat = to_bcd(i_item.value);
                OP_READ_RAW,
                OP_READ_DEC:  dat = 8'h00;
                default:      dat = 8'h00;
            endcase
            cap = 8'h00;
        end

        if (idle && !i_item.start_req) begin
            // idle tick, pins low
        end else if (r_phase >= LAST_TICK) begin
            res.done_res = 1'b1;
            if (mode[1])
                res.read_value = (mode == OP_READ_DEC) ? from_bcd(cap) : cap;
            n_phase = 6'd0;
        end else begin
            res.chip_enable = 1'b1;
            res.busy_res    = 1'b1;
            n_mode = mode;
            n_cmd  = cmd;
            n_data = dat;
            n_cap  = cap;
            if (second && mode[1]) begin
                res.io_drive = 1'b0;
                res.sclk     = !odd;
                if (odd)
                    n_cap = {i_item.io_in, cap[7:1]};
            end else if (second) begin
                res.io_out = dat[0];
                res.sclk   = odd;
                if (odd)
                    n_data = {1'b0, dat[7:1]};
            end else begin
                res.io_out = cmd[0];
                res.sclk   = odd;
                if (odd)
                    n_cmd = {1'b0, cmd[7:1]};
            end
            n_phase = r_phase + 6'd1;
        end
        o_res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_mode  <= '0;
            r_cmd   <= '0;
            r_data  <= '0;
            r_cap   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_cmd   <= n_cmd;
            r_data  <= n_data;
            r_cap   <= n_cap;
        end
    end

endmodule

// ===== rtl/three_wire_rtc_access_master.sv =====
// Three-wire RTC access master, one serial half-period tick per input transfer.
// Registered path: input register, then result register; an access spans 33 ticks
// (accepting tick to done tick). Throughput: one tick per cycle unless the output stalls.
// Rate set by the single-pass sequencer update between the two registers.
// Reset (i_rst_n low, synchronous): sequencer idle, all state zero, both stages empty.
// Depends on rtcam_pkg, rtcam_core and three_wire_rtc_access_master_defines.svh.
`include "three_wire_rtc_access_master_defines.svh"
module three_wire_rtc_access_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_req[0], opcode[2:1], reg_index[5:3], value[13:6], io_in[14], zero[15]
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sclk[0], io_out[1], io_drive[2], chip_enable[3], busy_res[4], done_res[5],
    // read_value[13:6], zero[15:14]
    output logic [15:0] m_axis_tdata
);
    import rtcam_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    logic    adv;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid)
            r_in <= t_item'(s_axis_tdata[ITEM_W-1:0]);
    end

    rtcam_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_item  (r_in),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv)
            r_out <= core_res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

    `RTCAM_ASSERT(a_busy_done_excl, i_clk, i_rst_n, !(r_out_valid && r_out.busy_res && r_out.done_res), "busy and done on the same tick")
    `RTCAM_ASSERT_IMPL(a_ce_means_busy, i_clk, i_rst_n, r_out_valid && r_out.chip_enable, r_out.busy_res, "chip enable outside an access")
    `RTCAM_ASSERT_IMPL(a_release_in_read, i_clk, i_rst_n, r_out_valid && !r_out.io_drive, r_out.busy_res && r_out.chip_enable && !r_out.io_out, "data line released outside read bits")
    `RTCAM_ASSERT_IMPL(a_idle_pins_low, i_clk, i_rst_n, r_out_valid && !r_out.busy_res, !r_out.sclk && !r_out.chip_enable && r_out.io_drive, "pins not parked outside an access")

endmodule
